// File: hw/rtl/pwb_pkg.sv
// Pose blend package: payload structs, queue entry, divider request/response
// and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwb_pkg;

  localparam int unsigned POSE_LIMIT_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned DIV_N_W        = 64;
  localparam int unsigned DIV_D_W        = 32;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [15:0] weight;
    logic               last_pose;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_trans_x;
    logic signed [31:0] out_trans_y;
    logic signed [31:0] out_trans_z;
    logic signed [15:0] out_rot_x;
    logic signed [15:0] out_rot_y;
    logic signed [15:0] out_rot_z;
    logic signed [15:0] out_rot_w;
    logic signed [31:0] out_scale_x;
    logic signed [31:0] out_scale_y;
    logic signed [31:0] out_scale_z;
    logic               no_weight;
  } out_t;

  // acc: sample contributes to the sums; entries without acc carry only the last mark
  typedef struct packed {
    in_t  data;
    logic acc;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/pwb_front.sv
// Front end: accepts samples, applies the sample limit and weight test,
// and pushes work entries into the queue. Depends on pwb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwb_front #(
  parameter int unsigned POSE_LIMIT = pwb_pkg::POSE_LIMIT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire pwb_pkg::in_t    in_data_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output pwb_pkg::entry_t      push_data_o
);

  localparam int unsigned CNT_W = $clog2(POSE_LIMIT + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             below_lim;
  logic             acc;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign below_lim  = cnt_q < CNT_W'(POSE_LIMIT);
  assign acc        = below_lim && (in_data_i.weight > 16'sd0);

  // zero-weight or over-limit samples without the last mark need no back-end work
  assign push_o           = accept && (acc || in_data_i.last_pose);
  assign push_data_o.data = in_data_i;
  assign push_data_o.acc  = acc;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_data_i.last_pose) begin
        cnt_d = '0;
      end else if (below_lim) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pwb_fifo.sv
// Short queue of work entries between front and back end.
// Depends on pwb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwb_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire pwb_pkg::entry_t  push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output pwb_pkg::entry_t       data_o,
  input  wire logic             pop_i
);

  localparam int unsigned DEPTH = pwb_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pwb_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pwb_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pwb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwb_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pwb_pkg::div_req_t req_i,
  output pwb_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned NW    = pwb_pkg::DIV_N_W;
  localparam int unsigned DW    = pwb_pkg::DIV_D_W;
  localparam int unsigned CNT_W = $clog2(NW);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    dq_q;
  logic [DW-1:0]    rem_q, div_q;
  logic [DW:0]      rem_sh;
  logic             fits;
  logic [DW:0]      rem_sub;

  assign rem_sh  = {rem_q, dq_q[NW-1]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dq_q   <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dq_q   <= req_i.dividend;
        rem_q  <= '0;
        div_q  <= req_i.divisor;
      end else if (busy_q) begin
        // quotient bits shift in where dividend bits leave
        rem_q <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        dq_q  <= {dq_q[NW-2:0], fits};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pwb_back.sv
// Back end: sequenced multiply-accumulate of the sums, then averaging,
// quaternion normalisation and the result register. Depends on pwb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwb_back #(
  parameter int unsigned POSE_LIMIT = pwb_pkg::POSE_LIMIT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              ent_valid_i,
  input  wire pwb_pkg::entry_t   ent_i,
  output logic                   pop_o,
  output pwb_pkg::div_req_t      div_req_o,
  input  wire pwb_pkg::div_rsp_t div_rsp_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output pwb_pkg::out_t          out_data_o
);

  localparam int unsigned WSUM_W = $clog2(POSE_LIMIT * 32768);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_FIN, S_TDIV, S_MAG, S_SHIFT, S_SQ, S_SQRT, S_RDIV, S_RESULT
  } state_e;

  state_e               state_q;
  pwb_pkg::entry_t      ent_q;
  logic [3:0]           k_q;
  logic [2:0]           f_q;
  logic signed [63:0]   sum_t_q [3];
  logic signed [63:0]   sum_s_q [3];
  logic signed [39:0]   sum_r_q [4];
  logic [WSUM_W-1:0]    sum_w_q;
  logic signed [57:0]   dot_q;
  logic                 flip_q;
  logic signed [55:0]   p_q;
  logic [39:0]          m_q [4];
  logic [59:0]          sq_q;
  logic [63:0]          n2_q, res_q, bit_q;
  logic [31:0]          norm_q;
  logic                 div_run_q, div_start_q;
  logic signed [31:0]   res_t_q [3];
  logic signed [31:0]   res_s_q [3];
  logic signed [15:0]   res_r_q [4];
  logic                 res_nw_q;
  logic                 out_valid_q;
  pwb_pkg::out_t        out_q;

  logic signed [15:0]   q_in [4];
  logic signed [31:0]   tr_in [3];
  logic signed [31:0]   sc_in [3];
  logic signed [39:0]   mul_a;
  logic signed [15:0]   mul_b;
  logic signed [55:0]   mul_p;
  logic [3:0]           t_c, ti4, ti7, ti10, ki4, ki7, ki10;
  logic signed [57:0]   dot_sum;
  logic signed [63:0]   sel_sum;
  logic [63:0]          sel_mag;
  logic [63:0]          rot_dividend;
  logic [63:0]          root_try;
  logic                 rot_big;

  assign q_in[0]  = ent_q.data.rot_x;
  assign q_in[1]  = ent_q.data.rot_y;
  assign q_in[2]  = ent_q.data.rot_z;
  assign q_in[3]  = ent_q.data.rot_w;
  assign tr_in[0] = ent_q.data.trans_x;
  assign tr_in[1] = ent_q.data.trans_y;
  assign tr_in[2] = ent_q.data.trans_z;
  assign sc_in[0] = ent_q.data.scale_x;
  assign sc_in[1] = ent_q.data.scale_y;
  assign sc_in[2] = ent_q.data.scale_z;

  // step k issues a product; step k consumes the product of step k-1
  assign t_c  = k_q - 4'd1;
  assign ki4  = k_q - 4'd4;
  assign ki7  = k_q - 4'd7;
  assign ki10 = k_q - 4'd10;
  assign ti4  = t_c - 4'd4;
  assign ti7  = t_c - 4'd7;
  assign ti10 = t_c - 4'd10;

  always_comb begin
    mul_a = sum_r_q[k_q[1:0]];
    mul_b = q_in[k_q[1:0]];
    if (k_q >= 4'd10) begin
      mul_a = {{24{q_in[ki10[1:0]][15]}}, q_in[ki10[1:0]]};
      mul_b = ent_q.data.weight;
    end else if (k_q >= 4'd7) begin
      mul_a = {{8{sc_in[ki7[1:0]][31]}}, sc_in[ki7[1:0]]};
      mul_b = ent_q.data.weight;
    end else if (k_q >= 4'd4) begin
      mul_a = {{8{tr_in[ki4[1:0]][31]}}, tr_in[ki4[1:0]]};
      mul_b = ent_q.data.weight;
    end
  end

  assign mul_p   = mul_a * mul_b;
  assign dot_sum = dot_q + {{2{p_q[55]}}, p_q};

  assign sel_sum  = (f_q < 3'd3) ? sum_t_q[f_q[1:0]] : sum_s_q[2'(f_q - 3'd3)];
  assign sel_mag  = sel_sum[63] ? 64'(-sel_sum) : 64'(sel_sum);
  assign rot_dividend = {20'd0, m_q[f_q[1:0]][29:0], 14'd0} + {33'd0, norm_q[31:1]};
  assign root_try = res_q + bit_q;
  assign rot_big  = (m_q[0][39:30] != '0) || (m_q[1][39:30] != '0) ||
                    (m_q[2][39:30] != '0) || (m_q[3][39:30] != '0);

  assign pop_o = (state_q == S_IDLE) && ent_valid_i;

  assign div_req_o.start    = div_start_q;
  assign div_req_o.dividend = (state_q == S_RDIV) ? rot_dividend : sel_mag;
  assign div_req_o.divisor  = (state_q == S_RDIV) ? norm_q : 32'(sum_w_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] qm);
    logic signed [31:0] r;
    if (!neg) begin
      r = (qm > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qm[31:0]);
    end else begin
      r = (qm > 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'(-qm));
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ent_q       <= '0;
      k_q         <= '0;
      f_q         <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_t_q[i] <= '0;
        sum_s_q[i] <= '0;
        res_t_q[i] <= '0;
        res_s_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        sum_r_q[i] <= '0;
        m_q[i]     <= '0;
        res_r_q[i] <= '0;
      end
      sum_w_q     <= '0;
      dot_q       <= '0;
      flip_q      <= 1'b0;
      p_q         <= '0;
      sq_q        <= '0;
      n2_q        <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      norm_q      <= '0;
      div_run_q   <= 1'b0;
      div_start_q <= 1'b0;
      res_nw_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (ent_valid_i) begin
            ent_q   <= ent_i;
            k_q     <= '0;
            dot_q   <= '0;
            state_q <= ent_i.acc ? S_ACC : S_FIN;
          end
        end
        S_ACC: begin
          if (k_q <= 4'd13) begin
            p_q <= mul_p;
          end
          if (k_q >= 4'd1) begin
            if (t_c <= 4'd2) begin
              dot_q <= dot_sum;
            end else if (t_c == 4'd3) begin
              flip_q <= (sum_w_q != '0) && dot_sum[57];
            end else if (t_c <= 4'd6) begin
              sum_t_q[ti4[1:0]] <= sum_t_q[ti4[1:0]] + 64'(p_q);
            end else if (t_c <= 4'd9) begin
              sum_s_q[ti7[1:0]] <= sum_s_q[ti7[1:0]] + 64'(p_q);
            end else begin
              sum_r_q[ti10[1:0]] <= flip_q ? sum_r_q[ti10[1:0]] - p_q[39:0]
                                           : sum_r_q[ti10[1:0]] + p_q[39:0];
            end
          end
          k_q <= k_q + 4'd1;
          if (k_q == 4'd14) begin
            sum_w_q <= sum_w_q + WSUM_W'(ent_q.data.weight[14:0]);
            state_q <= ent_q.data.last_pose ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          f_q <= '0;
          if (sum_w_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              res_t_q[i] <= '0;
              res_s_q[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
              res_r_q[i] <= '0;
            end
            res_nw_q <= 1'b1;
            state_q  <= S_RESULT;
          end else begin
            res_nw_q <= 1'b0;
            state_q  <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (!div_run_q) begin
            div_run_q   <= 1'b1;
            div_start_q <= 1'b1;
          end else if (div_rsp_i.done) begin
            div_run_q <= 1'b0;
            if (f_q < 3'd3) begin
              res_t_q[f_q[1:0]] <= sat32(sel_sum[63], div_rsp_i.quotient);
            end else begin
              res_s_q[2'(f_q - 3'd3)] <= sat32(sel_sum[63], div_rsp_i.quotient);
            end
            f_q <= f_q + 3'd1;
            if (f_q == 3'd5) begin
              state_q <= S_MAG;
            end
          end
        end
        S_MAG: begin
          for (int i = 0; i < 4; i++) begin
            m_q[i] <= sum_r_q[i][39] ? 40'(-sum_r_q[i]) : 40'(sum_r_q[i]);
          end
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          // one bit of shift a cycle until every magnitude is below 2^30
          if (rot_big) begin
            for (int i = 0; i < 4; i++) begin
              m_q[i] <= m_q[i] >> 1;
            end
          end else begin
            k_q     <= '0;
            n2_q    <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (k_q <= 4'd3) begin
            sq_q <= m_q[k_q[1:0]][29:0] * m_q[k_q[1:0]][29:0];
          end
          if (k_q >= 4'd1) begin
            n2_q <= n2_q + 64'(sq_q);
          end
          k_q <= k_q + 4'd1;
          if (k_q == 4'd4) begin
            res_q   <= '0;
            bit_q   <= 64'd1 << 62;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q != '0) begin
            if (n2_q >= root_try) begin
              n2_q  <= n2_q - root_try;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            norm_q <= res_q[31:0];
            f_q    <= '0;
            if (res_q == '0) begin
              res_r_q[0] <= '0;
              res_r_q[1] <= '0;
              res_r_q[2] <= '0;
              res_r_q[3] <= 16'sd16384;
              state_q    <= S_RESULT;
            end else begin
              state_q <= S_RDIV;
            end
          end
        end
        S_RDIV: begin
          if (!div_run_q) begin
            div_run_q   <= 1'b1;
            div_start_q <= 1'b1;
          end else if (div_rsp_i.done) begin
            div_run_q <= 1'b0;
            res_r_q[f_q[1:0]] <= sum_r_q[f_q[1:0]][39] ? $signed(16'(-div_rsp_i.quotient))
                                                       : $signed(div_rsp_i.quotient[15:0]);
            f_q <= f_q + 3'd1;
            if (f_q == 3'd3) begin
              state_q <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.out_trans_x <= res_t_q[0];
            out_q.out_trans_y <= res_t_q[1];
            out_q.out_trans_z <= res_t_q[2];
            out_q.out_rot_x   <= res_r_q[0];
            out_q.out_rot_y   <= res_r_q[1];
            out_q.out_rot_z   <= res_r_q[2];
            out_q.out_rot_w   <= res_r_q[3];
            out_q.out_scale_x <= res_s_q[0];
            out_q.out_scale_y <= res_s_q[1];
            out_q.out_scale_z <= res_s_q[2];
            out_q.no_weight   <= res_nw_q;
            for (int i = 0; i < 3; i++) begin
              sum_t_q[i] <= '0;
              sum_s_q[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
              sum_r_q[i] <= '0;
            end
            sum_w_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/weighted_pose_blend_top.sv
// Each weighted sample is summed through the shared multiplier; a last sample then
// adds six averaging divides, the magnitude shift, the squaring steps, the square
// root and four rotation divides on the bit-serial divider; the queue takes new samples meanwhile while it has room.
// Samples with no positive weight or over the limit take no queue slot unless they carry the last mark.
// Reset: asynchronous active low, clears all sums, the sample count and the queue.
// Top level of the pose blend; depends on pwb_pkg, pwb_front, pwb_fifo, pwb_div, pwb_back.
`timescale 1ns / 1ps
`default_nettype none

module weighted_pose_blend_top #(
  parameter int unsigned POSE_LIMIT = pwb_pkg::POSE_LIMIT_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pwb_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pwb_pkg::out_t      out_data_o
);

  logic              push, full, ent_valid, pop;
  pwb_pkg::entry_t   push_data, ent;
  pwb_pkg::div_req_t div_req;
  pwb_pkg::div_rsp_t div_rsp;

  pwb_front #(.POSE_LIMIT(POSE_LIMIT)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .full_i(full), .push_o(push), .push_data_o(push_data)
  );

  pwb_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .valid_o(ent_valid), .data_o(ent), .pop_i(pop)
  );

  pwb_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  pwb_back #(.POSE_LIMIT(POSE_LIMIT)) u_back (
    .clk_i, .rst_ni, .ent_valid_i(ent_valid), .ent_i(ent), .pop_o(pop),
    .div_req_o(div_req), .div_rsp_i(div_rsp),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

`default_nettype wire

// File: hw/rtl/pwb_chk.sv
// Port-level checker for the pose blend, bound to the top level.
// Depends on pwb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwb_chk (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire pwb_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire pwb_pkg::out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_weight |->
      out_data_o.out_trans_x == 0 && out_data_o.out_rot_w == 0 &&
      out_data_o.out_scale_z == 0 && out_data_o.out_rot_x == 0)
    else $error("zero-weight result carries data");

  a_rot_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.out_rot_w <= 16'sd16384 && out_data_o.out_rot_w >= -16'sd16384 &&
      out_data_o.out_rot_x <= 16'sd16384 && out_data_o.out_rot_x >= -16'sd16384)
    else $error("normalised rotation out of unit range");

endmodule

bind weighted_pose_blend_top pwb_chk u_chk (.*);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for weighted_pose_blend_top: random and directed pose samples,
// a cycle-free predictor of the blended result, scoreboard on the output channel.
// Depends on pwb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned POSE_MAX = pwb_pkg::POSE_LIMIT_DEF;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          out_ready_i = 1'b0;
  pwb_pkg::in_t  in_data_i = '0;
  logic          in_ready_o, out_valid_o;
  pwb_pkg::out_t out_data_o;

  weighted_pose_blend_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pwb_pkg::in_t  pose_queue[$];
  pwb_pkg::out_t blend_queue[$];
  int   send_idle_pct = 21;
  int   recv_idle_pct = 61;
  bit   stim_done = 1'b0;
  int   mismatches = 0;
  logic in_ready_q = 1'b0;

  // predictor state
  longint acc_trans[3], acc_rot[4], acc_scale[3];
  longint acc_weight;
  int     samples_seen;

  function automatic logic [31:0] mean32(longint sum, longint w);
    longint q;
    q = sum / w;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_blend();
    for (int i = 0; i < 3; i++) begin
      acc_trans[i] = 0;
      acc_scale[i] = 0;
    end
    for (int i = 0; i < 4; i++) acc_rot[i] = 0;
    acc_weight = 0;
    samples_seen = 0;
  endfunction

  function automatic void blend_sample(pwb_pkg::in_t s);
    longint w, dot;
    longint q[4], tr[3], sc[3];
    longint unsigned m[4], big, n2, nrm, r;
    int sh;
    pwb_pkg::out_t o;
    w = s.weight;
    if (w < 0) w = 0;
    q[0] = s.rot_x; q[1] = s.rot_y; q[2] = s.rot_z; q[3] = s.rot_w;
    tr[0] = s.trans_x; tr[1] = s.trans_y; tr[2] = s.trans_z;
    sc[0] = s.scale_x; sc[1] = s.scale_y; sc[2] = s.scale_z;
    if (samples_seen < POSE_MAX) begin
      samples_seen++;
      if (w > 0) begin
        dot = 0;
        for (int i = 0; i < 4; i++) dot += acc_rot[i] * q[i];
        // hemisphere alignment only once something is accumulated
        if (acc_weight > 0 && dot < 0)
          for (int i = 0; i < 4; i++) q[i] = -q[i];
        for (int i = 0; i < 3; i++) begin
          acc_trans[i] += tr[i] * w;
          acc_scale[i] += sc[i] * w;
        end
        for (int i = 0; i < 4; i++) acc_rot[i] += q[i] * w;
        acc_weight += w;
      end
    end
    if (!s.last_pose) return;
    o = '0;
    if (acc_weight == 0) begin
      o.no_weight = 1'b1;
    end else begin
      o.out_trans_x = mean32(acc_trans[0], acc_weight);
      o.out_trans_y = mean32(acc_trans[1], acc_weight);
      o.out_trans_z = mean32(acc_trans[2], acc_weight);
      o.out_scale_x = mean32(acc_scale[0], acc_weight);
      o.out_scale_y = mean32(acc_scale[1], acc_weight);
      o.out_scale_z = mean32(acc_scale[2], acc_weight);
      big = 0;
      for (int i = 0; i < 4; i++) begin
        m[i] = (acc_rot[i] < 0) ? -acc_rot[i] : acc_rot[i];
        if (m[i] > big) big = m[i];
      end
      sh = 0;
      while ((big >> sh) >= (64'd1 << 30)) sh++;
      n2 = 0;
      for (int i = 0; i < 4; i++) begin
        m[i] >>= sh;
        n2 += m[i] * m[i];
      end
      nrm = root64(n2);
      if (nrm == 0) begin
        o.out_rot_w = 16'sd16384;
      end else begin
        for (int i = 0; i < 4; i++) begin
          r = (m[i] * 16384 + nrm / 2) / nrm;
          if (acc_rot[i] < 0) r = -r;
          case (i)
            0: o.out_rot_x = r[15:0];
            1: o.out_rot_y = r[15:0];
            2: o.out_rot_z = r[15:0];
            default: o.out_rot_w = r[15:0];
          endcase
        end
      end
    end
    blend_queue.push_back(o);
    clear_blend();
  endfunction

  function automatic pwb_pkg::in_t rand_pose(bit last);
    pwb_pkg::in_t s;
    int k;
    s.trans_x = $urandom; s.trans_y = $urandom; s.trans_z = $urandom;
    s.scale_x = $urandom; s.scale_y = $urandom; s.scale_z = $urandom;
    k = $urandom_range(0, 3);
    // mostly modest values so averages land in range, sometimes full width
    if (k != 0) begin
      s.trans_x = $signed(s.trans_x) >>> 8; s.trans_y = $signed(s.trans_y) >>> 12;
      s.scale_x = $signed(s.scale_x) >>> 10; s.scale_z = $signed(s.scale_z) >>> 14;
    end
    s.rot_x = 16'($urandom); s.rot_y = 16'($urandom);
    s.rot_z = 16'($urandom); s.rot_w = 16'($urandom);
    k = $urandom_range(0, 9);
    if (k == 0) s.weight = 16'($urandom);
    else if (k == 1) s.weight = 0;
    else if (k == 2) s.weight = -$signed(16'($urandom_range(1, 32768)));
    else s.weight = 16'($urandom_range(1, 4096));
    s.last_pose = last;
    return s;
  endfunction

  task automatic push_pose(pwb_pkg::in_t s);
    pose_queue.push_back(s);
    blend_sample(s);
  endtask

  // driver: falling edge launches, stalls only between transfers
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid_i && !in_ready_q)) begin
        if (pose_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i <= pose_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // acceptance seen at the rising edge, used by the driver at the next falling edge
  always @(posedge clk_i) begin
    in_ready_q <= in_valid_i && in_ready_o;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blend_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        pwb_pkg::out_t e;
        e = blend_queue.pop_front();
        if (out_data_o !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", e, out_data_o);
        end
      end
    end
  end

  task automatic drain();
    while (pose_queue.size() != 0 || blend_queue.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  initial begin
    pwb_pkg::in_t s;
    int n, joints;
    clear_blend();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: empty joint, all-negative, extremes, degenerate rotation, overflow count
    s = '0; s.last_pose = 1; push_pose(s);
    s = rand_pose(1); s.weight = -16'sd32768; push_pose(s);
    s = '0; s.trans_x = 32'h7fffffff; s.trans_y = 32'h80000000; s.trans_z = 32'hffffffff;
    s.scale_x = 32'h80000000; s.scale_y = 32'h7fffffff; s.scale_z = 32'h00010000;
    s.rot_x = 16'h7fff; s.rot_y = 16'h8000; s.rot_z = 16'hffff; s.rot_w = 16'h4000;
    s.weight = 16'sh7fff; push_pose(s);
    s.rot_x = 16'h8000; s.rot_y = 16'h7fff; s.rot_z = 16'h0001; s.rot_w = 16'hc000;
    s.weight = 16'sd1; s.last_pose = 1; push_pose(s);
    s = rand_pose(0); s.rot_x = 0; s.rot_y = 0; s.rot_z = 0; s.rot_w = 0;
    s.weight = 16'sd4096; s.last_pose = 1; push_pose(s);
    s = rand_pose(0); s.weight = 16'sd4096; push_pose(s);
    s.rot_x = -s.rot_x; s.rot_y = -s.rot_y; s.rot_z = -s.rot_z; s.rot_w = -s.rot_w;
    push_pose(s);
    s.last_pose = 1; push_pose(s);
    for (int i = 0; i < POSE_MAX + 2; i++) push_pose(rand_pose(i == POSE_MAX + 1));

    n = 0;
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 21 : 0;
      while (n < 480 * (phase + 1)) begin
        // joints of random length, occasionally longer than the limit
        joints = ($urandom_range(0, 9) == 0) ? $urandom_range(POSE_MAX, POSE_MAX + 3)
                                             : $urandom_range(1, 6);
        for (int i = 0; i < joints; i++) push_pose(rand_pose(i == joints - 1));
        n += joints;
      end
    end
    drain();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && blend_queue.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #400ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pwb_pkg.sv
hw/rtl/pwb_front.sv
hw/rtl/pwb_fifo.sv
hw/rtl/pwb_div.sv
hw/rtl/pwb_back.sv
hw/rtl/weighted_pose_blend_top.sv
hw/rtl/pwb_chk.sv
bench/testbench.sv
